// ----- hdl/psw_pkg.sv -----
// shared constants, types and helpers for the priority scheduler
`timescale 1ns / 1ps

package psw_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int BURST_W   = 16;
  localparam int PRIO_W    = 8;
  localparam int TIME_W    = 20;
  localparam int OUT_IDX_W = 4;
  localparam int ENTRY_W   = BURST_W + PRIO_W;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  // control from the sequencer to the compare unit
  typedef struct packed {
    logic clear;
    logic sample;
    logic take;
  } sel_ctrl_t;

  // current best candidate held by the compare unit
  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   idx;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } best_t;

  // arrival index reduced or extended to the output index width
  function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W+OUT_IDX_W-1:0] ext;
    ext = {{OUT_IDX_W{1'b0}}, idx};
    return ext[OUT_IDX_W-1:0];
  endfunction

endpackage

// ----- hdl/priority_schedule_wait_times.sv -----
// Non-preemptive priority scheduler top level: store, sequencer and result registers.
// An item without the end mark is stored while the store has room; busy stays low.
// After the item with the end mark, each of the n held entries takes one selection pass:
// the pass reads the entry ram once per entry through the compare unit.
// Results are emitted one per pass and never stall.
// Reset clears the entry count, the sequencer and the strobe; stored entries stay undefined.
`timescale 1ns / 1ps

module priority_schedule_wait_times (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [psw_pkg::BURST_W-1:0]   burst_time_i,
  input  logic [psw_pkg::PRIO_W-1:0]    priority_level_i,
  input  logic                          last_process_i,
  output logic                          result_valid_o,
  output logic [psw_pkg::OUT_IDX_W-1:0] process_index_o,
  output logic [psw_pkg::BURST_W-1:0]   burst_out_o,
  output logic [psw_pkg::PRIO_W-1:0]    priority_out_o,
  output logic [psw_pkg::TIME_W-1:0]    waiting_time_o,
  output logic [psw_pkg::TIME_W-1:0]    turnaround_time_o,
  output logic                          last_result_o
);
  import psw_pkg::*;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   rd_addr_q, rd_addr_d;
  logic               rd_pend_q, rd_pend_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]   emitted_q, emitted_d;
  logic [TIME_W-1:0]  elapsed_q, elapsed_d;
  logic               res_vld_q, res_vld_d;

  logic [OUT_IDX_W-1:0] res_idx_q;
  logic [BURST_W-1:0]   res_burst_q;
  logic [PRIO_W-1:0]    res_prio_q;
  logic [TIME_W-1:0]    res_wait_q;
  logic [TIME_W-1:0]    res_turn_q;
  logic                 res_last_q, res_last_d;

  logic               accept;
  logic               wr_en;
  logic [ENTRY_W-1:0] rd_data;
  logic [TIME_W-1:0]  turn_sum;
  sel_ctrl_t          sel_ctrl;
  best_t              best;

  assign accept   = start && (state_q == S_IDLE);
  assign wr_en    = accept && (count_q < CNT_W'(MAX_PROCS));
  assign turn_sum = elapsed_q + TIME_W'(best.burst);

  // entry store: burst in the upper bits, priority in the lower bits
  psw_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_PROCS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(count_q[IDX_W-1:0]),
    .wdata_i({burst_time_i, priority_level_i}),
    .raddr_i(rd_addr_q[IDX_W-1:0]),
    .rdata_o(rd_data)
  );

  psw_sel u_sel (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (sel_ctrl),
    .rd_idx_i  (rd_idx_q),
    .rd_burst_i(rd_data[ENTRY_W-1:PRIO_W]),
    .rd_prio_i (rd_data[PRIO_W-1:0]),
    .best_o    (best)
  );

  // sequencer: store items, then one selection pass per result
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rd_addr_d  = rd_addr_q;
    rd_pend_d  = 1'b0;
    rd_idx_d   = rd_idx_q;
    emitted_d  = emitted_q;
    elapsed_d  = elapsed_q;
    res_vld_d  = 1'b0;
    res_last_d = 1'b0;
    sel_ctrl   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (wr_en) begin
            count_d = count_q + CNT_W'(1);
          end
          if (last_process_i) begin
            state_d        = S_SCAN;
            rd_addr_d      = '0;
            emitted_d      = '0;
            elapsed_d      = '0;
            sel_ctrl.clear = 1'b1;
          end
        end
      end
      S_SCAN: begin
        sel_ctrl.sample = rd_pend_q;
        if (rd_addr_q < count_q) begin
          rd_pend_d = 1'b1;
          rd_idx_d  = rd_addr_q[IDX_W-1:0];
          rd_addr_d = rd_addr_q + CNT_W'(1);
        end else if (!rd_pend_q) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        sel_ctrl.take = 1'b1;
        res_vld_d     = 1'b1;
        elapsed_d     = turn_sum;
        emitted_d     = emitted_q + CNT_W'(1);
        if (emitted_q + CNT_W'(1) == count_q) begin
          res_last_d = 1'b1;
          count_d    = '0;
          state_d    = S_IDLE;
        end else begin
          rd_addr_d = '0;
          state_d   = S_SCAN;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      rd_addr_q <= '0;
      rd_pend_q <= 1'b0;
      emitted_q <= '0;
      elapsed_q <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_addr_q <= rd_addr_d;
      rd_pend_q <= rd_pend_d;
      emitted_q <= emitted_d;
      elapsed_q <= elapsed_d;
      res_vld_q <= res_vld_d;
    end
  end

  // result payload, loaded while emitting
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    if (state_q == S_EMIT) begin
      res_idx_q   <= to_out_idx(best.idx);
      res_burst_q <= best.burst;
      res_prio_q  <= best.prio;
      res_wait_q  <= elapsed_q;
      res_turn_q  <= turn_sum;
      res_last_q  <= res_last_d;
    end
  end

  assign busy              = (state_q != S_IDLE);
  assign result_valid_o    = res_vld_q;
  assign process_index_o   = res_idx_q;
  assign burst_out_o       = res_burst_q;
  assign priority_out_o    = res_prio_q;
  assign waiting_time_o    = res_wait_q;
  assign turnaround_time_o = res_turn_q;
  assign last_result_o     = res_last_q;

  // a strobe only follows an emit cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == S_EMIT))
    else $error("result strobe without a preceding emit cycle");

  // an emit cycle always has a pending candidate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> best.valid)
    else $error("emit cycle without a selected entry");

  // the scan address never runs past the held entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (rd_addr_q <= count_q))
    else $error("scan address beyond entry count");

  // the entry count stays within capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_PROCS))
    else $error("entry count beyond capacity");

endmodule

// ----- hdl/psw_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module psw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- hdl/psw_sel.sv -----
// shared compare unit: tracks the pending entry with the lowest priority value in a scan
`timescale 1ns / 1ps

module psw_sel (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  psw_pkg::sel_ctrl_t          ctrl_i,
  input  logic [psw_pkg::IDX_W-1:0]   rd_idx_i,
  input  logic [psw_pkg::BURST_W-1:0] rd_burst_i,
  input  logic [psw_pkg::PRIO_W-1:0]  rd_prio_i,
  output psw_pkg::best_t              best_o
);
  import psw_pkg::*;

  best_t                best_q, best_d;
  logic [MAX_PROCS-1:0] done_q, done_d;
  logic                 better;

  // strict compare keeps the earliest arrival on equal priority
  assign better = ctrl_i.sample && !done_q[rd_idx_i] &&
                  (!best_q.valid || (rd_prio_i < best_q.prio));

  always_comb begin
    best_d = best_q;
    done_d = done_q;
    if (ctrl_i.clear) begin
      best_d.valid = 1'b0;
      done_d       = '0;
    end else if (ctrl_i.take) begin
      best_d.valid         = 1'b0;
      done_d[best_q.idx]   = 1'b1;
    end else if (better) begin
      best_d.valid = 1'b1;
      best_d.idx   = rd_idx_i;
      best_d.burst = rd_burst_i;
      best_d.prio  = rd_prio_i;
    end
  end

  // candidate and done bits, all cleared on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
      done_q <= '0;
    end else begin
      best_q <= best_d;
      done_q <= done_d;
    end
  end

  assign best_o = best_q;

endmodule
